// File: hdl/spwm_pkg.sv
// Package for the servo PWM generator with command sweep.
// Holds the sweep mode codes, command characters and register indexes.
// No dependencies; imported by servo_pwm_with_command_sweep.
package spwm_pkg;

	localparam int unsigned REG_BITS   = 16;
	localparam int unsigned INDEX_BITS = 3;
	localparam int unsigned CHAR_BITS  = 8;

	typedef logic [REG_BITS-1:0]   reg_word_t;
	typedef logic [INDEX_BITS-1:0] reg_index_t;
	typedef logic [CHAR_BITS-1:0]  char_t;

	// Configuration register indexes.
	localparam reg_index_t IDX_PERIOD_TOP   = 3'd0;
	localparam reg_index_t IDX_CENTER_WIDTH = 3'd1;
	localparam reg_index_t IDX_MANUAL_MIN   = 3'd2;
	localparam reg_index_t IDX_MANUAL_MAX   = 3'd3;
	localparam reg_index_t IDX_SWEEP_MIN    = 3'd4;
	localparam reg_index_t IDX_SWEEP_MAX    = 3'd5;

	// Reset values of the configuration registers.
	localparam reg_word_t RST_PERIOD_TOP   = 16'd1001;
	localparam reg_word_t RST_CENTER_WIDTH = 16'd75;
	localparam reg_word_t RST_MANUAL_MIN   = 16'd55;
	localparam reg_word_t RST_MANUAL_MAX   = 16'd95;
	localparam reg_word_t RST_SWEEP_MIN    = 16'd65;
	localparam reg_word_t RST_SWEEP_MAX    = 16'd92;

	// Item kinds.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_CMD  = 1'b1;

	// Command characters.
	localparam char_t CH_UP     = 8'h71; // 'q'
	localparam char_t CH_DOWN   = 8'h61; // 'a'
	localparam char_t CH_RIGHT  = 8'h52; // 'R'
	localparam char_t CH_LEFT   = 8'h4C; // 'L'
	localparam char_t CH_CENTER = 8'h5A; // 'Z'

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_RIGHT  = 2'd1,
		MODE_LEFT   = 2'd2,
		MODE_CENTER = 2'd3
	} sweep_mode_t;

endpackage

// File: hdl/servo_pwm_with_command_sweep.sv
// Servo PWM generator driven by timer ticks and command bytes, with sweep modes.
// Uses spwm_pkg for mode codes, command characters and register indexes.
// Single module: state update, two-word output buffer and configuration registers.
//
//  channel  | handshake            | payload                 | direction
//  ---------+----------------------+-------------------------+----------
//  in       | in_valid / in_ready  | op, rx_byte             | into block
//  out      | out_valid / out_ready| pwm_level, pulse_width  | out of block
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data     | into block
//
// One input word is taken per cycle while in_ready is high; a tick word yields its
// result word, registered into the output buffer, and a command word yields none.
// The output side is a two-entry buffer, so in_ready drops only when both entries
// are full. cfg_ready is always high. Reset (arst_n low) clears the counter, toggle,
// sweep mode and buffer and reloads all registers and the width to defaults.
module servo_pwm_with_command_sweep #(
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	input  spwm_pkg::char_t      rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 pwm_level,
	output spwm_pkg::reg_word_t  pulse_width,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  spwm_pkg::reg_index_t cfg_index,
	input  spwm_pkg::reg_word_t  cfg_data
);
	import spwm_pkg::*;

	// Comparisons are done at the wider of the counter and the register width.
	localparam int unsigned CMP_BITS = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

	// Configuration registers.
	reg_word_t period_top_q, center_width_q, manual_min_q, manual_max_q;
	reg_word_t sweep_min_q, sweep_max_q;

	// Block state.
	logic [COUNT_BITS-1:0] period_count_q;
	reg_word_t             width_q;
	sweep_mode_t           mode_q;
	logic                  toggle_q;

	// Output buffer: head entry drives the ports, skid entry catches overflow.
	logic      head_valid_q, skid_valid_q;
	logic      head_level_q, skid_level_q;
	reg_word_t head_width_q, skid_width_q;

	logic                  in_fire, tick_fire, cmd_fire, out_fire;
	logic [CMP_BITS-1:0]   count_ext, top_ext, width_ext;
	logic                  level_new, wrap;
	logic [COUNT_BITS-1:0] count_next;
	reg_word_t             width_tick, width_cmd;
	logic                  toggle_next;
	sweep_mode_t           mode_cmd;

	assign cfg_ready = 1'b1;
	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign tick_fire = in_fire && (op == OP_TICK);
	assign cmd_fire  = in_fire && (op == OP_CMD);
	assign out_valid   = head_valid_q;
	assign pwm_level   = head_level_q;
	assign pulse_width = head_width_q;
	assign out_fire    = head_valid_q && out_ready;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_top_q   <= RST_PERIOD_TOP;
			center_width_q <= RST_CENTER_WIDTH;
			manual_min_q   <= RST_MANUAL_MIN;
			manual_max_q   <= RST_MANUAL_MAX;
			sweep_min_q    <= RST_SWEEP_MIN;
			sweep_max_q    <= RST_SWEEP_MAX;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				IDX_PERIOD_TOP:   period_top_q   <= cfg_data;
				IDX_CENTER_WIDTH: center_width_q <= cfg_data;
				IDX_MANUAL_MIN:   manual_min_q   <= cfg_data;
				IDX_MANUAL_MAX:   manual_max_q   <= cfg_data;
				IDX_SWEEP_MIN:    sweep_min_q    <= cfg_data;
				IDX_SWEEP_MAX:    sweep_max_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Tick path: the level is taken against the count before it advances. The
	// counter wraps to zero at the top value; when the top lies beyond the
	// counter's range it rolls over on its own and no sweep step is taken.
	always_comb begin
		count_ext   = CMP_BITS'(period_count_q);
		top_ext     = CMP_BITS'(period_top_q);
		width_ext   = CMP_BITS'(width_q);
		level_new   = (count_ext < width_ext);
		wrap        = !(count_ext < top_ext);
		count_next  = wrap ? '0 : (period_count_q + COUNT_BITS'(1));
		width_tick  = width_q;
		toggle_next = toggle_q;
		if (wrap) begin
			toggle_next = !toggle_q;
			// The sweep step is taken on every second wrap.
			if (toggle_q) begin
				unique case (mode_q)
					MODE_RIGHT: begin
						if (width_q < sweep_max_q) width_tick = width_q + 16'd1;
					end
					MODE_LEFT: begin
						if (width_q > sweep_min_q) width_tick = width_q - 16'd1;
					end
					MODE_CENTER: width_tick = center_width_q;
					MODE_NONE: ;
					default: ;
				endcase
			end
		end
	end

	// Command path: a nudge never carries the width past the manual limits.
	always_comb begin
		width_cmd = width_q;
		mode_cmd  = mode_q;
		unique case (rx_byte)
			CH_UP: begin
				if (width_q < manual_max_q) width_cmd = width_q + 16'd1;
			end
			CH_DOWN: begin
				if (width_q > manual_min_q) width_cmd = width_q - 16'd1;
			end
			CH_RIGHT:  mode_cmd = MODE_RIGHT;
			CH_LEFT:   mode_cmd = MODE_LEFT;
			CH_CENTER: mode_cmd = MODE_CENTER;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_count_q <= '0;
			width_q        <= RST_CENTER_WIDTH;
			mode_q         <= MODE_NONE;
			toggle_q       <= 1'b0;
		end else if (tick_fire) begin
			period_count_q <= count_next;
			width_q        <= width_tick;
			toggle_q       <= toggle_next;
		end else if (cmd_fire) begin
			width_q <= width_cmd;
			mode_q  <= mode_cmd;
		end
	end

	// Output buffer control. A new result goes to the head when the head is
	// free or draining, otherwise into the skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) skid_valid_q <= 1'b0;
		end else if (tick_fire) begin
			if (!head_valid_q || out_fire) head_valid_q <= 1'b1;
			else skid_valid_q <= 1'b1;
		end else if (out_fire) begin
			head_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				head_level_q <= skid_level_q;
				head_width_q <= skid_width_q;
			end
		end else if (tick_fire) begin
			if (!head_valid_q || out_fire) begin
				head_level_q <= level_new;
				head_width_q <= width_tick;
			end else begin
				skid_level_q <= level_new;
				skid_width_q <= width_tick;
			end
		end
	end

	// The skid entry is only ever filled behind a waiting head entry.
	a_skid_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> head_valid_q)
		else $error("skid entry holds a word while head is empty");

	// A command word moves the width by at most one step.
	a_cmd_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> (width_q == $past(width_q)) ||
			(width_q == 16'($past(width_q) + 16'd1)) ||
			(width_q == 16'($past(width_q) - 16'd1)))
		else $error("command changed the width by more than one");

	// The counter moves only on an accepted tick.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick_fire |=> $stable(period_count_q))
		else $error("period counter moved without a tick");

	// Without an accepted word the width does not change.
	a_width_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(width_q))
		else $error("width changed without an input word");

endmodule

// File: bench/servo_pwm_with_command_sweep_tb.sv
// Self-checking bench for servo_pwm_with_command_sweep: ticks and command words in,
// pulse level and width words out, with the six registers reprogrammed between phases.
// Depends on spwm_pkg and the servo_pwm_with_command_sweep module; nothing else.
module servo_pwm_with_command_sweep_tb;

	import spwm_pkg::*;

	localparam int unsigned COUNT_BITS = 16;

	// Clock period 12, so the clock flips every 6 time units.
	localparam int HALF_PERIOD = 6;
	// Cycles in a row with no word moving on any channel before the run gives up.
	// The longest honest quiet spell is the forced receiver hold-off plus a sender
	// gap, far below this.
	localparam int IDLE_LIMIT = 1000;
	// Length of the deliberate output hold-off that fills the block's buffer.
	localparam int HOLD_OFF_CYCLES = 90;
	// A tick's result is registered in the block's output buffer; this pause
	// gives margin once nothing more is expected.
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_PHASES = 10;
	localparam int WORDS_PER_PHASE = 165;

	// Register indexes past the end of the list; the block must ignore writes to them.
	localparam reg_index_t IDX_SPARE_LO = 3'd6;
	localparam reg_index_t IDX_SPARE_HI = 3'd7;

	typedef struct packed {
		logic      level;
		reg_word_t width;
	} pulse_t;

	// Tracks the servo state alongside the block and holds the pulse words that
	// accepted ticks are owed, oldest first.
	class pulse_scoreboard;
		localparam int MAX_REPORTS = 10;

		reg_word_t period_top, center_width, manual_min, manual_max, sweep_min, sweep_max;
		logic [COUNT_BITS-1:0] period_count;
		reg_word_t width_now;
		sweep_mode_t mode;
		bit half_toggle;
		pulse_t owed_pulses[$];
		int failures;
		int reported;

		function new();
			period_top   = RST_PERIOD_TOP;
			center_width = RST_CENTER_WIDTH;
			manual_min   = RST_MANUAL_MIN;
			manual_max   = RST_MANUAL_MAX;
			sweep_min    = RST_SWEEP_MIN;
			sweep_max    = RST_SWEEP_MAX;
			period_count = '0;
			width_now    = RST_CENTER_WIDTH;
			mode         = MODE_NONE;
			half_toggle  = 1'b0;
			failures     = 0;
			reported     = 0;
		endfunction

		function void write_reg(reg_index_t idx, reg_word_t val);
			case (idx)
				IDX_PERIOD_TOP:   period_top   = val;
				IDX_CENTER_WIDTH: center_width = val;
				IDX_MANUAL_MIN:   manual_min   = val;
				IDX_MANUAL_MAX:   manual_max   = val;
				IDX_SWEEP_MIN:    sweep_min    = val;
				IDX_SWEEP_MAX:    sweep_max    = val;
				default: ;
			endcase
		endfunction

		// Only every second wrap moves the width; the others just arm the toggle.
		function void wrap_period();
			period_count = '0;
			if (half_toggle) begin
				half_toggle = 1'b0;
				case (mode)
					MODE_RIGHT:  if (width_now < sweep_max) width_now++;
					MODE_LEFT:   if (width_now > sweep_min) width_now--;
					MODE_CENTER: width_now = center_width;
					default: ;
				endcase
			end else begin
				half_toggle = 1'b1;
			end
		endfunction

		function void note_word(logic kind, char_t ch);
			pulse_t p;
			if (kind == OP_CMD) begin
				case (ch)
					CH_UP:     if (width_now < manual_max) width_now++;
					CH_DOWN:   if (width_now > manual_min) width_now--;
					CH_RIGHT:  mode = MODE_RIGHT;
					CH_LEFT:   mode = MODE_LEFT;
					CH_CENTER: mode = MODE_CENTER;
					default: ;
				endcase
			end else begin
				p.level = (period_count < width_now);
				if (period_count < period_top)
					period_count = period_count + 1'b1;
				else
					wrap_period();
				p.width = width_now;
				owed_pulses.push_back(p);
			end
		endfunction

		function void check_word(logic level, reg_word_t width);
			pulse_t want;
			if (owed_pulses.size() == 0) begin
				failures++;
				if (reported < MAX_REPORTS) begin
					$display("unexpected pulse word: level %0b width %0d", level, width);
					reported++;
				end
			end else begin
				want = owed_pulses.pop_front();
				if (level !== want.level || width !== want.width) begin
					failures++;
					if (reported < MAX_REPORTS) begin
						$display({"pulse mismatch: expected level %0b width %0d,",
							" got level %0b width %0d"},
							want.level, want.width, level, width);
						reported++;
					end
				end
			end
		endfunction

		function int pending();
			return owed_pulses.size();
		endfunction
	endclass

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic       op        = OP_TICK;
	char_t      rx_byte   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       pwm_level;
	reg_word_t  pulse_width;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	reg_index_t cfg_index = IDX_PERIOD_TOP;
	reg_word_t  cfg_data  = '0;

	pulse_scoreboard sb = new();
	reg_word_t phase_regs [6];
	char_t command_set [5] = '{CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_CENTER};
	// Raised by the stimulus to ask the receiver for one long hold-off.
	bit hold_off_req = 1'b0;
	int idle_cycles = 0;

	servo_pwm_with_command_sweep #(
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pwm_level(pwm_level),
		.pulse_width(pulse_width),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Every output word taken at an edge is checked against the oldest owed pulse.
	// Values read right after the edge are the ones the block presented before it.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_word(pwm_level, pulse_width);
	end

	// Watchdog: any word moving on any channel resets the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: segments of random length, each with its own stall style, so that
	// stalls land on every phase of the servo period. Style zero never stalls.
	// When asked, it holds off for a long stretch so the two-entry buffer fills
	// and in_ready has to drop while the sender keeps offering words.
	initial begin : receiver
		int seg_len;
		int style;
		forever begin
			seg_len = $urandom_range(10, 80);
			style = $urandom_range(0, 3);
			for (int i = 0; i < seg_len; i++) begin
				@(posedge clk);
				if (hold_off_req) begin
					hold_off_req = 1'b0;
					out_ready <= 1'b0;
					repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
				end else begin
					case (style)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= (i % 4 == 0);
						default: out_ready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	// Offers one word and waits for the edge that takes it. Valid is left high so a
	// following word in the same burst goes out without a bubble.
	task automatic send_word(input logic kind, input char_t ch);
		in_valid <= 1'b1;
		op <= kind;
		rx_byte <= ch;
		do @(posedge clk); while (!in_ready);
		sb.note_word(kind, ch);
	endtask

	// Mostly ticks, carrying random bytes that the block must ignore; then real
	// commands; a few random command bytes as noise.
	task automatic send_random_word();
		int pick;
		char_t ch;
		pick = $urandom_range(0, 99);
		ch = char_t'($urandom);
		if (pick < 65)
			send_word(OP_TICK, ch);
		else if (pick < 92)
			send_word(OP_CMD, command_set[$urandom_range(0, 4)]);
		else
			send_word(OP_CMD, ch);
	endtask

	task automatic run_random(input int count);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < count; i++) begin
				send_random_word();
				sent++;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Stops offering, waits for every owed pulse, then lets a trailing command
	// word settle before the block counts as idle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input reg_word_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// Writes all six registers plus one index past the list with random data.
	task automatic apply_config(input reg_index_t spare);
		write_reg(IDX_PERIOD_TOP,   phase_regs[IDX_PERIOD_TOP]);
		write_reg(IDX_CENTER_WIDTH, phase_regs[IDX_CENTER_WIDTH]);
		write_reg(IDX_MANUAL_MIN,   phase_regs[IDX_MANUAL_MIN]);
		write_reg(IDX_MANUAL_MAX,   phase_regs[IDX_MANUAL_MAX]);
		write_reg(IDX_SWEEP_MIN,    phase_regs[IDX_SWEEP_MIN]);
		write_reg(IDX_SWEEP_MAX,    phase_regs[IDX_SWEEP_MAX]);
		write_reg(spare, reg_word_t'($urandom));
		cfg_valid <= 1'b0;
	endtask

	function automatic void load_regs(reg_word_t top, reg_word_t center, reg_word_t mmin,
		reg_word_t mmax, reg_word_t smin, reg_word_t smax);
		phase_regs[IDX_PERIOD_TOP]   = top;
		phase_regs[IDX_CENTER_WIDTH] = center;
		phase_regs[IDX_MANUAL_MIN]   = mmin;
		phase_regs[IDX_MANUAL_MAX]   = mmax;
		phase_regs[IDX_SWEEP_MIN]    = smin;
		phase_regs[IDX_SWEEP_MAX]    = smax;
	endfunction

	// The first phases pin the extremes: a zero period top so every tick wraps
	// with the width driven to zero and then to full scale, and a full-range
	// period with all nudges and sweeps locked out. One phase takes every
	// register fully random; the rest use short periods so sweeps happen often.
	function automatic void choose_phase(input int p);
		case (p)
			0: load_regs(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
			1: load_regs(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
			2: load_regs(16'hFFFF, 16'h8000, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
			4: load_regs(reg_word_t'($urandom), reg_word_t'($urandom),
				reg_word_t'($urandom), reg_word_t'($urandom),
				reg_word_t'($urandom), reg_word_t'($urandom));
			default: load_regs(reg_word_t'($urandom_range(0, 12)),
				reg_word_t'($urandom_range(0, 30)), reg_word_t'($urandom_range(0, 20)),
				reg_word_t'($urandom_range(10, 40)), reg_word_t'($urandom_range(0, 20)),
				reg_word_t'($urandom_range(5, 35)));
		endcase
	endfunction

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: ticks with both extremes of the ignored byte, command
		// bytes that mean nothing, and the two manual nudges.
		send_word(OP_TICK, 8'hFF);
		send_word(OP_CMD, 8'h00);
		send_word(OP_CMD, 8'hFF);
		send_word(OP_CMD, CH_UP);
		send_word(OP_CMD, CH_UP);
		send_word(OP_CMD, CH_DOWN);
		send_word(OP_TICK, 8'h00);
		drain();

		// A period of two ticks: first wraps with no sweep mode set, then each mode
		// gets two wraps so it is applied exactly once.
		load_regs(16'd1, 16'd70, RST_MANUAL_MIN, RST_MANUAL_MAX, RST_SWEEP_MIN, RST_SWEEP_MAX);
		apply_config(IDX_SPARE_LO);
		repeat (4) send_word(OP_TICK, char_t'($urandom));
		send_word(OP_CMD, CH_RIGHT);
		repeat (4) send_word(OP_TICK, char_t'($urandom));
		send_word(OP_CMD, CH_LEFT);
		repeat (4) send_word(OP_TICK, char_t'($urandom));
		send_word(OP_CMD, CH_CENTER);
		repeat (4) send_word(OP_TICK, char_t'($urandom));
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			choose_phase(p);
			apply_config((p % 2 == 0) ? IDX_SPARE_HI : IDX_SPARE_LO);
			if (p == 3)
				hold_off_req = 1'b1;
			run_random(WORDS_PER_PHASE);
			drain();
		end

		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
